[rtl/core/rcc_pkg.sv]
package rcc_pkg;

    // Widths of the calibration registers and of the result pulse.
    localparam int CFG_W  = 12;
    localparam int DZ_W   = 6;
    localparam int MODE_W = 4;
    localparam int OUT_W  = 12;

    // Result word width on the master side, padded to whole bytes.
    localparam int M_TDATA_W = 16;

    // APB address width: eight registers at byte addresses 0..28.
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    // Rescale arithmetic widths: product of two register-wide magnitudes.
    localparam int PROD_W = 2 * CFG_W;

    // Centre dead zone constants.
    localparam logic [CFG_W-1:0] CENTRE_PULSE = 12'd1500;
    localparam logic [CFG_W-1:0] DZ_LOW_EDGE  = 12'd1450;
    localparam logic [CFG_W-1:0] DZ_HIGH_EDGE = 12'd1550;
    localparam logic [DZ_W-1:0]  DZ_LIMIT     = 6'd50;

    // Mode bit positions.
    localparam int MODE_FILTER  = 0;
    localparam int MODE_REVERSE = 1;
    localparam int MODE_FS_EN   = 2;
    localparam int MODE_DZ_OFF  = 3;

    // Register reset values.
    localparam logic [CFG_W-1:0]  RST_IN_MIN   = 12'd1000;
    localparam logic [CFG_W-1:0]  RST_IN_MAX   = 12'd2000;
    localparam logic [CFG_W-1:0]  RST_OUT_MIN  = 12'd1000;
    localparam logic [CFG_W-1:0]  RST_OUT_MAX  = 12'd2000;
    localparam logic [CFG_W-1:0]  RST_FS_LEVEL = 12'd975;
    localparam logic [CFG_W-1:0]  RST_FS_FLOOR = 12'd900;
    localparam logic [DZ_W-1:0]   RST_DEAD     = 6'd0;
    localparam logic [MODE_W-1:0] RST_MODE     = 4'd1;

    // Register indexes (word address).
    typedef enum logic [2:0] {
        REG_IN_MIN   = 3'd0,
        REG_IN_MAX   = 3'd1,
        REG_OUT_MIN  = 3'd2,
        REG_OUT_MAX  = 3'd3,
        REG_FS_LEVEL = 3'd4,
        REG_FS_FLOOR = 3'd5,
        REG_DEAD     = 3'd6,
        REG_MODE     = 3'd7
    } reg_idx_t;

    // Calibration set handed from the register file to the datapath.
    typedef struct packed {
        logic [CFG_W-1:0]  in_min;
        logic [CFG_W-1:0]  in_max;
        logic [CFG_W-1:0]  out_min;
        logic [CFG_W-1:0]  out_max;
        logic [CFG_W-1:0]  fs_level;
        logic [CFG_W-1:0]  fs_floor;
        logic [DZ_W-1:0]   dead_zone;
        logic [MODE_W-1:0] mode;
    } cfg_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_PREP,
        ST_MUL,
        ST_DIV,
        ST_FIN
    } state_t;

endpackage

[rtl/core/rcc_regs.sv]
module rcc_regs
    import rcc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic [CFG_W-1:0]  in_min_reg;
    logic [CFG_W-1:0]  in_max_reg;
    logic [CFG_W-1:0]  out_min_reg;
    logic [CFG_W-1:0]  out_max_reg;
    logic [CFG_W-1:0]  fs_level_reg;
    logic [CFG_W-1:0]  fs_floor_reg;
    logic [DZ_W-1:0]   dead_reg;
    logic [MODE_W-1:0] mode_reg;
    logic              wr_en;
    reg_idx_t          idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);

    // Register writes; values are cut to the register width.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_min_reg   <= RST_IN_MIN;
            in_max_reg   <= RST_IN_MAX;
            out_min_reg  <= RST_OUT_MIN;
            out_max_reg  <= RST_OUT_MAX;
            fs_level_reg <= RST_FS_LEVEL;
            fs_floor_reg <= RST_FS_FLOOR;
            dead_reg     <= RST_DEAD;
            mode_reg     <= RST_MODE;
        end else if (wr_en) begin
            unique case (idx)
                REG_IN_MIN:   in_min_reg   <= pwdata[CFG_W-1:0];
                REG_IN_MAX:   in_max_reg   <= pwdata[CFG_W-1:0];
                REG_OUT_MIN:  out_min_reg  <= pwdata[CFG_W-1:0];
                REG_OUT_MAX:  out_max_reg  <= pwdata[CFG_W-1:0];
                REG_FS_LEVEL: fs_level_reg <= pwdata[CFG_W-1:0];
                REG_FS_FLOOR: fs_floor_reg <= pwdata[CFG_W-1:0];
                REG_DEAD:     dead_reg     <= pwdata[DZ_W-1:0];
                REG_MODE:     mode_reg     <= pwdata[MODE_W-1:0];
            endcase
        end
    end

    // Read-back multiplexer.
    always_comb begin
        unique case (idx)
            REG_IN_MIN:   prdata = APB_DW'(in_min_reg);
            REG_IN_MAX:   prdata = APB_DW'(in_max_reg);
            REG_OUT_MIN:  prdata = APB_DW'(out_min_reg);
            REG_OUT_MAX:  prdata = APB_DW'(out_max_reg);
            REG_FS_LEVEL: prdata = APB_DW'(fs_level_reg);
            REG_FS_FLOOR: prdata = APB_DW'(fs_floor_reg);
            REG_DEAD:     prdata = APB_DW'(dead_reg);
            REG_MODE:     prdata = APB_DW'(mode_reg);
        endcase
    end

    assign cfg.in_min    = in_min_reg;
    assign cfg.in_max    = in_max_reg;
    assign cfg.out_min   = out_min_reg;
    assign cfg.out_max   = out_max_reg;
    assign cfg.fs_level  = fs_level_reg;
    assign cfg.fs_floor  = fs_floor_reg;
    assign cfg.dead_zone = dead_reg;
    assign cfg.mode      = mode_reg;

endmodule

[rtl/core/rcc_mult.sv]
module rcc_mult
    import rcc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [CFG_W-1:0]   mcand,
    input  logic [CFG_W-1:0]   mplier,
    output logic               done,
    output logic [PROD_W-1:0]  product
);

    localparam int CNT_W = $clog2(CFG_W);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CFG_W-1:0]  a_reg;
    logic [CFG_W-1:0]  hi_reg;
    logic [CFG_W-1:0]  lo_reg;
    logic [CFG_W:0]    sum;

    // One multiplier bit per cycle: add the multiplicand into the upper
    // half when the low bit is set, then shift the whole accumulator right.
    assign sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, a_reg} : '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(CFG_W - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Accumulator and operand registers.
    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg  <= mcand;
            hi_reg <= '0;
            lo_reg <= mplier;
        end else if (busy_reg) begin
            hi_reg <= sum[CFG_W:1];
            lo_reg <= {sum[0], lo_reg[CFG_W-1:1]};
        end
    end

    assign done    = done_reg;
    assign product = {hi_reg, lo_reg};

endmodule

[rtl/core/rcc_div.sv]
module rcc_div
    import rcc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [PROD_W-1:0]  dividend,
    input  logic [CFG_W-1:0]   divisor,
    output logic               done,
    output logic [PROD_W-1:0]  quotient
);

    localparam int CNT_W = $clog2(PROD_W);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CFG_W-1:0]  den_reg;
    logic [CFG_W-1:0]  rem_reg;
    logic [PROD_W-1:0] num_reg;
    logic [CFG_W:0]    shifted;
    logic [CFG_W+1:0]  diff;
    logic              fits;

    // Restoring division, one quotient bit per cycle. The dividend shifts
    // out at the top while quotient bits shift in at the bottom.
    assign shifted = {rem_reg, num_reg[PROD_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, den_reg};
    assign fits    = ~diff[CFG_W+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(PROD_W - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder and dividend/quotient shift register.
    always_ff @(posedge aclk) begin
        if (start) begin
            den_reg <= divisor;
            rem_reg <= '0;
            num_reg <= dividend;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[CFG_W-1:0] : shifted[CFG_W-1:0];
            num_reg <= {num_reg[PROD_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = num_reg;

endmodule

[rtl/core/rc_channel_conditioner_unit.sv]
// Channel        Direction  Handshake                    Contents
// s_ (stream)    in         s_tvalid / s_tready          raw pulse word
// m_ (stream)    out        m_tvalid / m_tready          conditioned pulse, failsafe
// APB            in/out     psel, penable, pready        calibration registers
//
// A word passes ST_CALC, ST_PREP and ST_FIN when the result needs no rescaling
// (dead zone, below range, empty input range), adding ST_MUL and ST_DIV when it
// is rescaled: the bit-serial multiplier runs 12 steps, the restoring divider 24.
// Reset is synchronous and active low; it restores the register defaults
// and clears the filter and the failsafe latch.
// A new word is taken while a finished result still waits in the output
// register; the sequencer stalls only in its last state until that slot frees.
module rc_channel_conditioner_unit
    import rcc_pkg::*;
#(
    parameter int PULSE_BITS = 12
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // [PULSE_BITS-1:0] pulse_in, rest zero
    input  logic [((PULSE_BITS+7)/8)*8-1:0] s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [11:0] pulse_out, [15:12] zero
    output logic [M_TDATA_W-1:0]         m_tdata,
    // [0] failsafe_active
    output logic                         m_tuser,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [APB_AW-1:0]            paddr,
    input  logic [APB_DW-1:0]            pwdata,
    output logic [APB_DW-1:0]            prdata,
    output logic                         pready
);

    // Compare width for the filtered pulse against register values.
    localparam int CW = (PULSE_BITS > CFG_W) ? PULSE_BITS : CFG_W;
    // Signed width of the clamped and possibly reversed pulse.
    localparam int RW = CFG_W + 2;
    // Signed width of the final sum before saturation.
    localparam int SW = PROD_W + 2;
    localparam logic [PULSE_BITS-1:0] PULSE_MASK = '1;

    cfg_t                    cfg;
    state_t                  state_reg;
    state_t                  state_next;

    logic [PULSE_BITS-1:0]   pin_reg;
    logic [PULSE_BITS-1:0]   filt_reg;
    logic                    flag_reg;
    logic [RW-1:0]           base_reg;
    logic                    use_q_reg;
    logic                    neg_reg;
    logic [CFG_W-1:0]        den_reg;
    logic                    m_tvalid_reg;
    logic [OUT_W-1:0]        pout_reg;
    logic                    fs_out_reg;

    logic                    mul_start;
    logic                    div_start;
    logic                    out_load;
    logic                    mul_done;
    logic                    div_done;
    logic [PROD_W-1:0]       product;
    logic [PROD_W-1:0]       quotient;

    logic [PULSE_BITS:0]     filt_sum;
    logic [PULSE_BITS-1:0]   filt_next;
    logic [CW-1:0]           filt_next_e;
    logic [CW-1:0]           level_e;
    logic                    flag_next;

    logic [CW-1:0]           fe;
    logic [CFG_W-1:0]        lo_bound;
    logic [CFG_W-1:0]        rc;
    logic [RW-1:0]           rcr;
    logic [RW-1:0]           rc_off;
    logic                    above_min;
    logic                    range_ok;
    logic [DZ_W-1:0]         dz;
    logic [CW-1:0]           dz_lo;
    logic [CW-1:0]           dz_hi;
    logic                    zone_hit;
    logic [CFG_W:0]          span;
    logic [CFG_W-1:0]        span_mag;
    logic [RW-1:0]           base_next;
    logic                    use_q_next;

    logic [SW-1:0]           q_signed;
    logic [SW-1:0]           res;
    logic [PULSE_BITS-1:0]   sat;

    rcc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Filter and failsafe latch update.
    assign filt_sum    = {1'b0, pin_reg} + {1'b0, filt_reg};
    assign filt_next   = cfg.mode[MODE_FILTER] ? filt_sum[PULSE_BITS:1] : pin_reg;
    assign filt_next_e = CW'(filt_next);
    assign level_e     = CW'(cfg.fs_level);

    always_comb begin
        priority if (!cfg.mode[MODE_FS_EN]) begin
            flag_next = 1'b0;
        end else if (filt_next_e > level_e) begin
            flag_next = 1'b0;
        end else if (filt_next_e < level_e) begin
            flag_next = 1'b1;
        end else begin
            flag_next = flag_reg;
        end
    end

    // Clamp, reverse, dead zone and rescale decision on the filtered value.
    assign fe       = CW'(filt_reg);
    assign lo_bound = flag_reg ? cfg.fs_floor : cfg.in_min;

    always_comb begin
        priority if (fe < CW'(lo_bound)) begin
            rc = lo_bound;
        end else if (fe > CW'(cfg.in_max)) begin
            rc = cfg.in_max;
        end else begin
            rc = CFG_W'(fe);
        end
    end

    assign rcr = cfg.mode[MODE_REVERSE]
               ? RW'(cfg.in_max) + RW'(cfg.in_min) - RW'(rc)
               : RW'(rc);
    assign rc_off    = rcr - RW'(cfg.in_min);
    assign above_min = $signed(rcr) > $signed(RW'(cfg.in_min));
    assign range_ok  = cfg.in_max > cfg.in_min;

    assign dz       = (cfg.dead_zone > DZ_LIMIT) ? DZ_LIMIT : cfg.dead_zone;
    assign dz_lo    = CW'(DZ_LOW_EDGE) + CW'(dz);
    assign dz_hi    = CW'(DZ_HIGH_EDGE) - CW'(dz);
    assign zone_hit = !cfg.mode[MODE_DZ_OFF] && (dz != '0) && (fe > dz_lo) && (fe < dz_hi);

    assign span     = {1'b0, cfg.out_max} - {1'b0, cfg.out_min};
    assign span_mag = span[CFG_W] ? CFG_W'(-span) : span[CFG_W-1:0];

    always_comb begin
        use_q_next = 1'b0;
        priority if (zone_hit) begin
            base_next = RW'(CENTRE_PULSE);
        end else if (!above_min) begin
            base_next = flag_reg ? rcr : RW'(cfg.out_min);
        end else begin
            base_next  = RW'(cfg.out_min);
            use_q_next = range_ok;
        end
    end

    rcc_mult u_mult (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .mcand   (span_mag),
        .mplier  (rc_off[CFG_W-1:0]),
        .done    (mul_done),
        .product (product)
    );

    rcc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (product),
        .divisor  (den_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // Final sum and saturation to the pulse range.
    assign q_signed = neg_reg ? -SW'(quotient) : SW'(quotient);
    assign res      = {{(SW-RW){base_reg[RW-1]}}, base_reg} + (use_q_reg ? q_signed : '0);

    always_comb begin
        priority if (res[SW-1]) begin
            sat = '0;
        end else if (res > SW'(PULSE_MASK)) begin
            sat = PULSE_MASK;
        end else begin
            sat = res[PULSE_BITS-1:0];
        end
    end

    // Sequencer state register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Sequencer next state and strobes.
    always_comb begin
        state_next = state_reg;
        mul_start  = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                state_next = ST_PREP;
            end
            ST_PREP: begin
                if (use_q_next) begin
                    mul_start  = 1'b1;
                    state_next = ST_MUL;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_MUL: begin
                if (mul_done) begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);

    // Channel state and output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filt_reg     <= '0;
            flag_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (state_reg == ST_CALC) begin
                filt_reg <= filt_next;
                flag_reg <= flag_next;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            pin_reg <= s_tdata[PULSE_BITS-1:0];
        end
        if (state_reg == ST_PREP) begin
            base_reg  <= base_next;
            use_q_reg <= use_q_next;
            neg_reg   <= span[CFG_W];
            den_reg   <= cfg.in_max - cfg.in_min;
        end
        if (out_load) begin
            pout_reg   <= OUT_W'(sat);
            fs_out_reg <= flag_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W-OUT_W){1'b0}}, pout_reg};
    assign m_tuser  = fs_out_reg;

    // The multiplier and divider finish only while the sequencer waits on them.
    a_mul_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> state_reg == ST_MUL)
        else $error("multiplier finished outside the multiply state");

    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside the divide state");

    // A loaded result is presented on the next cycle.
    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_tvalid && m_tuser == $past(flag_reg))
        else $error("result not presented after load");

    // With failsafe disabled the latch is cleared by the next word.
    a_fs_disabled: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CALC && !cfg.mode[MODE_FS_EN]) |=> !flag_reg)
        else $error("failsafe latch set while disabled");

endmodule
